// ===== rtl/lbc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line break converter package
// Shared types, register indexes and character codes for the converter.
// ============================================================================
package lbc_pkg;

    localparam int CHAR_W              = 16;
    localparam int CFG_W               = 2;
    localparam int CFG_INDEX_W         = 2;
    localparam int DEFAULT_CHAR_BITS   = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST   = 2'd1;

    localparam logic [CFG_W-1:0] SRC_ANY  = 2'd0;
    localparam logic [CFG_W-1:0] SRC_CR   = 2'd1;
    localparam logic [CFG_W-1:0] SRC_LF   = 2'd2;
    localparam logic [CFG_W-1:0] SRC_CRLF = 2'd3;

    localparam logic [CFG_W-1:0] DST_CR    = 2'd0;
    localparam logic [CFG_W-1:0] DST_LF    = 2'd1;
    localparam logic [CFG_W-1:0] DST_CRLF  = 2'd2;
    localparam logic [CFG_W-1:0] DST_SPACE = 2'd3;

    localparam logic [CFG_W-1:0] SOURCE_RESET = SRC_ANY;
    localparam logic [CFG_W-1:0] DEST_RESET   = DST_LF;

    localparam logic [CHAR_W-1:0] CODE_CR    = 16'd13;
    localparam logic [CHAR_W-1:0] CODE_LF    = 16'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 16'd32;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_in;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              has_char;
        logic              last_out;
    } out_item_t;

    // One queued command: a first character, and for a CRLF break a trailing LF.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has_char;
        logic              pair;
        logic              last;
    } cmd_t;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } back_state_t;

endpackage

// ===== rtl/lbc_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line break converter front end
// Holds the configuration and the pending CR flag, classifies each input
// character and pushes one command per character that yields a result.
// ============================================================================
module lbc_front #(
    parameter int CHAR_BITS = lbc_pkg::DEFAULT_CHAR_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  lbc_pkg::in_item_t                    in_data,
    input  logic                                 cfg_wen,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 q_full,
    output logic                                 q_push,
    output lbc_pkg::cmd_t                        q_cmd
);

    localparam logic [lbc_pkg::CHAR_W-1:0] CHAR_MASK =
        lbc_pkg::CHAR_W'((33'd1 << CHAR_BITS) - 33'd1);

    logic [lbc_pkg::CFG_W-1:0]  src_reg;
    logic [lbc_pkg::CFG_W-1:0]  dst_reg;
    logic                       pending_reg;
    logic                       pending_next;
    logic [lbc_pkg::CHAR_W-1:0] c;
    logic                       accept;
    logic                       same;
    logic                       pairing;
    logic                       swallow;
    logic                       is_break;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign c        = in_data.char_in & CHAR_MASK;

    assign pairing = (src_reg == lbc_pkg::SRC_ANY) || (src_reg == lbc_pkg::SRC_CRLF);
    assign same    = ((src_reg == lbc_pkg::SRC_CR)   && (dst_reg == lbc_pkg::DST_CR))
                  || ((src_reg == lbc_pkg::SRC_LF)   && (dst_reg == lbc_pkg::DST_LF))
                  || ((src_reg == lbc_pkg::SRC_CRLF) && (dst_reg == lbc_pkg::DST_CRLF));
    assign swallow = !same && pending_reg && pairing && (c == lbc_pkg::CODE_LF);

    always_comb
    begin
        unique case (src_reg)
            lbc_pkg::SRC_ANY: is_break = (c == lbc_pkg::CODE_CR) || (c == lbc_pkg::CODE_LF);
            lbc_pkg::SRC_LF:  is_break = (c == lbc_pkg::CODE_LF);
            default:          is_break = (c == lbc_pkg::CODE_CR);
        endcase
    end

    always_comb
    begin
        q_cmd.ch       = c;
        q_cmd.has_char = 1'b1;
        q_cmd.pair     = 1'b0;
        q_cmd.last     = in_data.last_in;
        pending_next   = 1'b0;
        priority if (same)
        begin
            pending_next = 1'b0;
        end
        else if (swallow)
        begin
            q_cmd.ch       = '0;
            q_cmd.has_char = 1'b0;
        end
        else if (is_break)
        begin
            pending_next = pairing && (c == lbc_pkg::CODE_CR);
            unique case (dst_reg)
                lbc_pkg::DST_CR:   q_cmd.ch = lbc_pkg::CODE_CR;
                lbc_pkg::DST_LF:   q_cmd.ch = lbc_pkg::CODE_LF;
                lbc_pkg::DST_CRLF:
                begin
                    q_cmd.ch   = lbc_pkg::CODE_CR;
                    q_cmd.pair = 1'b1;
                end
                default:           q_cmd.ch = lbc_pkg::CODE_SPACE;
            endcase
        end
        else
        begin
            pending_next = 1'b0;
        end
        if (in_data.last_in)
        begin
            pending_next = 1'b0;
        end
    end

    assign q_push = accept && !(swallow && !in_data.last_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg     <= lbc_pkg::SOURCE_RESET;
            dst_reg     <= lbc_pkg::DEST_RESET;
            pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen && (cfg_index == lbc_pkg::REG_SOURCE))
            begin
                src_reg <= cfg_data;
            end
            if (cfg_wen && (cfg_index == lbc_pkg::REG_DEST))
            begin
                dst_reg <= cfg_data;
            end
            if (accept)
            begin
                pending_reg <= pending_next;
            end
        end
    end

    // A transaction that ends a string leaves no CR pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_in |=> !pending_reg)
        else $error("pending CR survived the end of a string");

endmodule

// ===== rtl/lbc_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line break converter command queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
module lbc_queue #(
    parameter int DEPTH = lbc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lbc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output lbc_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lbc_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into a full queue");

endmodule

// ===== rtl/lbc_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line break converter back end
// Expands each queued command into one or two results and holds them in an
// output register until the downstream side takes them.
// ============================================================================
module lbc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  lbc_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output lbc_pkg::out_item_t out_data
);

    lbc_pkg::back_state_t state_reg;
    lbc_pkg::back_state_t state_next;
    lbc_pkg::out_item_t   out_reg;
    lbc_pkg::out_item_t   out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign load      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        if (load)
        begin
            unique case (state_reg)
                lbc_pkg::BK_FIRST:
                begin
                    if (head_valid)
                    begin
                        out_valid_next    = 1'b1;
                        out_next.char_out = head_cmd.ch;
                        out_next.has_char = head_cmd.has_char;
                        if (head_cmd.pair)
                        begin
                            out_next.last_out = 1'b0;
                            state_next        = lbc_pkg::BK_SECOND;
                        end
                        else
                        begin
                            out_next.last_out = head_cmd.last;
                            pop               = 1'b1;
                        end
                    end
                end
                lbc_pkg::BK_SECOND:
                begin
                    out_valid_next    = 1'b1;
                    out_next.char_out = lbc_pkg::CODE_LF;
                    out_next.has_char = 1'b1;
                    out_next.last_out = head_cmd.last;
                    pop               = 1'b1;
                    state_next        = lbc_pkg::BK_FIRST;
                end
                default:
                begin
                    state_next = lbc_pkg::BK_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbc_pkg::BK_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // The second half of a CRLF break still has its command at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lbc_pkg::BK_SECOND) |-> head_valid)
        else $error("second break character without a queued command");

    // The first half of a CRLF break is never marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lbc_pkg::BK_SECOND) |-> (out_valid_reg && !out_reg.last_out))
        else $error("first half of a CRLF break is missing or marked last");

endmodule

// ===== rtl/line_break_converter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line break converter
// Converts a character stream between CR, LF and CRLF line break conventions, or turns breaks into spaces.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   in_data   (char_in, last_in)
//   out      output     out_valid / out_ready out_data  (char_out, has_char, last_out)
//   cfg      input      cfg_wen               cfg_index, cfg_data
//
// One character per cycle is sustained while the output takes every result and no
// break becomes CRLF; such a break leaves the single output register of the back end
// as a CR and then an LF, and holds its command in the queue meanwhile.
// A lone LF swallowed after a CR yields no transaction unless it ends a string.
// Reset is asynchronous and active low; it restores the default conventions.
// Stalls on the output fill the command queue and then drop in_ready.
// ============================================================================
module line_break_converter #(
    parameter int CHAR_BITS   = lbc_pkg::DEFAULT_CHAR_BITS,
    parameter int QUEUE_DEPTH = lbc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lbc_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lbc_pkg::out_item_t              out_data,
    input  logic                            cfg_wen,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]       cfg_data
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_head_valid;
    lbc_pkg::cmd_t q_push_cmd;
    lbc_pkg::cmd_t q_head_cmd;

    lbc_front #(
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    lbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    lbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== bench/line_break_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line break converter checker
// Watches the input, output and register ports of the converter. It keeps
// its own copy of the conventions and of the pending CR, predicts the output
// characters of every input transaction, and compares each output
// transaction field by field with the oldest prediction.
// ============================================================================
module line_break_checker #(
    parameter int CHAR_BITS = lbc_pkg::DEFAULT_CHAR_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  lbc_pkg::in_item_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  lbc_pkg::out_item_t              out_data,
    input  logic                            cfg_wen,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]       cfg_data,
    output int                              errors,
    output int                              waiting,
    output int                              items_seen,
    output int                              results_seen,
    output int                              markers_seen
);

    localparam logic [lbc_pkg::CHAR_W-1:0] CHAR_MASK =
        lbc_pkg::CHAR_W'((32'd1 << CHAR_BITS) - 1);

    logic [lbc_pkg::CFG_W-1:0] source_conv;
    logic [lbc_pkg::CFG_W-1:0] dest_conv;
    logic                      cr_waiting;
    lbc_pkg::out_item_t        expected_chars[$];

    task automatic report(input string what, input logic [lbc_pkg::CHAR_W-1:0] want,
                          input logic [lbc_pkg::CHAR_W-1:0] got);
        errors++;
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endtask

    function automatic void convert_char(input lbc_pkg::in_item_t item);
        lbc_pkg::out_item_t         res [2];
        int                         n;
        logic [lbc_pkg::CHAR_W-1:0] c;
        logic                       pairing;
        logic                       same;
        logic                       is_break;
        n = 0;
        c = item.char_in & CHAR_MASK;
        pairing = (source_conv == lbc_pkg::SRC_ANY) || (source_conv == lbc_pkg::SRC_CRLF);
        same = (source_conv == lbc_pkg::SRC_CR && dest_conv == lbc_pkg::DST_CR) ||
               (source_conv == lbc_pkg::SRC_LF && dest_conv == lbc_pkg::DST_LF) ||
               (source_conv == lbc_pkg::SRC_CRLF && dest_conv == lbc_pkg::DST_CRLF);
        if (same)
        begin
            res[0] = '{c, 1'b1, 1'b0};
            n = 1;
            cr_waiting = 1'b0;
        end
        else if (cr_waiting && pairing && c == lbc_pkg::CODE_LF)
        begin
            cr_waiting = 1'b0;
            if (item.last_in)
            begin
                res[0] = '{'0, 1'b0, 1'b0};
                n = 1;
            end
        end
        else
        begin
            case (source_conv)
                lbc_pkg::SRC_ANY: is_break = (c == lbc_pkg::CODE_CR) || (c == lbc_pkg::CODE_LF);
                lbc_pkg::SRC_LF:  is_break = (c == lbc_pkg::CODE_LF);
                default:          is_break = (c == lbc_pkg::CODE_CR);
            endcase
            if (is_break)
            begin
                case (dest_conv)
                    lbc_pkg::DST_CR:
                    begin
                        res[0] = '{lbc_pkg::CODE_CR, 1'b1, 1'b0};
                        n = 1;
                    end
                    lbc_pkg::DST_LF:
                    begin
                        res[0] = '{lbc_pkg::CODE_LF, 1'b1, 1'b0};
                        n = 1;
                    end
                    lbc_pkg::DST_CRLF:
                    begin
                        res[0] = '{lbc_pkg::CODE_CR, 1'b1, 1'b0};
                        res[1] = '{lbc_pkg::CODE_LF, 1'b1, 1'b0};
                        n = 2;
                    end
                    default:
                    begin
                        res[0] = '{lbc_pkg::CODE_SPACE, 1'b1, 1'b0};
                        n = 1;
                    end
                endcase
                cr_waiting = pairing && (c == lbc_pkg::CODE_CR);
            end
            else
            begin
                res[0] = '{c, 1'b1, 1'b0};
                n = 1;
                cr_waiting = 1'b0;
            end
        end
        if (item.last_in)
        begin
            if (n > 0)
            begin
                res[n-1].last_out = 1'b1;
            end
            cr_waiting = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_chars.push_back(res[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lbc_pkg::out_item_t want;
        if (!rst_n)
        begin
            source_conv = lbc_pkg::SOURCE_RESET;
            dest_conv = lbc_pkg::DEST_RESET;
            cr_waiting = 1'b0;
            expected_chars.delete();
            errors = 0;
            items_seen = 0;
            results_seen = 0;
            markers_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (!out_data.has_char)
                begin
                    markers_seen++;
                end
                if (expected_chars.size() == 0)
                begin
                    report("output transaction with nothing expected", '0,
                           out_data.char_out);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_data.char_out !== want.char_out)
                    begin
                        report("char_out", want.char_out, out_data.char_out);
                    end
                    if (out_data.has_char !== want.has_char)
                    begin
                        report("has_char", lbc_pkg::CHAR_W'(want.has_char),
                               lbc_pkg::CHAR_W'(out_data.has_char));
                    end
                    if (out_data.last_out !== want.last_out)
                    begin
                        report("last_out", lbc_pkg::CHAR_W'(want.last_out),
                               lbc_pkg::CHAR_W'(out_data.last_out));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                items_seen++;
                convert_char(in_data);
            end
            if (cfg_wen)
            begin
                if (cfg_index == lbc_pkg::REG_SOURCE)
                begin
                    source_conv = cfg_data;
                end
                else if (cfg_index == lbc_pkg::REG_DEST)
                begin
                    dest_conv = cfg_data;
                end
            end
        end
        waiting = expected_chars.size();
    end

endmodule

// ===== bench/tb_line_break_converter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line break converter testbench
// Drives character strings through the converter under every pair of source
// and destination conventions, with random gaps and stalls on both channels
// and one long output stall, and lets the checker judge every transaction.
// ============================================================================
module tb_line_break_converter;

    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 72;
    localparam int SETTLE      = 6;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    lbc_pkg::in_item_t               in_data;
    logic                            out_valid;
    logic                            out_ready;
    lbc_pkg::out_item_t              out_data;
    logic                            cfg_wen;
    logic [lbc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lbc_pkg::CFG_W-1:0]       cfg_data;

    int errors;
    int waiting;
    int items_seen;
    int results_seen;
    int markers_seen;
    bit quiet;
    bit hold_req;
    int stall_left;

    line_break_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_break_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .waiting      (waiting),
        .items_seen   (items_seen),
        .results_seen (results_seen),
        .markers_seen (markers_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [lbc_pkg::CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            return lbc_pkg::CODE_CR;
        end
        if (r < 38)
        begin
            return lbc_pkg::CODE_LF;
        end
        if (r < 43)
        begin
            return lbc_pkg::CODE_SPACE;
        end
        if (r < 46)
        begin
            return 16'hFFFF;
        end
        if (r < 49)
        begin
            return 16'h0000;
        end
        if (r < 55)
        begin
            return {8'($urandom_range(1, 255)),
                    $urandom_range(0, 1) ? lbc_pkg::CODE_CR[7:0] : lbc_pkg::CODE_LF[7:0]};
        end
        return 16'($urandom());
    endfunction

    // The receiver stalls at random, and holds off for a long stretch on request.
    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic send(input logic [lbc_pkg::CHAR_W-1:0] c, input logic last);
        int gap;
        in_valid <= 1'b1;
        in_data <= '{c, last};
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [lbc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lbc_pkg::CFG_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_conventions(input logic [lbc_pkg::CFG_W-1:0] src,
                                   input logic [lbc_pkg::CFG_W-1:0] dst);
        write_reg(lbc_pkg::REG_SOURCE, src);
        write_reg(lbc_pkg::REG_DEST, dst);
    endtask

    task automatic send_text(input int count);
        int  len;
        bit  open_end;
        bit  terminal;
        while (count > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            open_end = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len && count > 0; i++)
            begin
                terminal = (i == len - 1) && !open_end;
                if ($urandom_range(0, 6) == 0)
                begin
                    send(lbc_pkg::CODE_CR, 1'b0);
                    send(lbc_pkg::CODE_LF, terminal);
                    count -= 2;
                end
                else
                begin
                    send(pick_char(), terminal);
                    count--;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset conventions: any break in, LF out.
        send(16'h0000, 1'b0);
        send(16'hFFFF, 1'b0);
        send(16'h0041, 1'b0);
        send(lbc_pkg::CODE_CR, 1'b0);
        send(lbc_pkg::CODE_LF, 1'b0);
        send(lbc_pkg::CODE_LF, 1'b0);
        send(16'h010D, 1'b0);
        send(lbc_pkg::CODE_CR, 1'b1);
        send(lbc_pkg::CODE_CR, 1'b0);
        send(lbc_pkg::CODE_LF, 1'b1);
        send(16'h007A, 1'b1);
        wait_idle();
        write_reg(2'd2, 2'd3);
        write_reg(2'd3, 2'd2);
        set_conventions(lbc_pkg::SRC_CRLF, lbc_pkg::DST_CRLF);
        send(lbc_pkg::CODE_CR, 1'b0);
        send(lbc_pkg::CODE_LF, 1'b0);
        send(16'h8000, 1'b1);
        wait_idle();
        set_conventions(lbc_pkg::SRC_CRLF, lbc_pkg::DST_SPACE);
        send(lbc_pkg::CODE_LF, 1'b0);
        send(lbc_pkg::CODE_CR, 1'b0);
        wait_idle();
        // A CR kept across a change to a source that does not pair breaks.
        set_conventions(lbc_pkg::SRC_CR, lbc_pkg::DST_CRLF);
        send(lbc_pkg::CODE_LF, 1'b0);
        wait_idle();
        set_conventions(lbc_pkg::SRC_ANY, lbc_pkg::DST_CRLF);
        send(lbc_pkg::CODE_CR, 1'b0);
        wait_idle();
        // A CR kept across a change, then swallowing the LF under the new setting.
        set_conventions(lbc_pkg::SRC_CRLF, lbc_pkg::DST_LF);
        send(lbc_pkg::CODE_LF, 1'b0);
        send(lbc_pkg::CODE_CR, 1'b1);
        wait_idle();
        set_conventions(lbc_pkg::SRC_LF, lbc_pkg::DST_CR);
        send(lbc_pkg::CODE_LF, 1'b0);
        send(lbc_pkg::CODE_CR, 1'b0);
        send(lbc_pkg::CODE_LF, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 16; ph++)
        begin
            set_conventions(lbc_pkg::CFG_W'(ph >> 2), lbc_pkg::CFG_W'(ph));
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(lbc_pkg::CFG_INDEX_W'($urandom_range(2, 3)),
                          lbc_pkg::CFG_W'($urandom()));
            end
            quiet = (ph == 5) || ($urandom_range(0, 4) == 0);
            if (ph == 5)
            begin
                hold_req = 1'b1;
            end
            send_text(PHASE_ITEMS);
            wait_idle();
        end

        $display("Covered %0d input and %0d output transactions over all 16 convention pairs,",
                 items_seen, results_seen);
        $display("with %0d empty end markers and one %0d-cycle output stall.",
                 markers_seen, HOLD_CYCLES);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
